// ===== hdl/fix15_unpremultiply_to_rgba8_unit_assert.svh =====
// Assertion macros shared by the unpremultiply unit.
`ifndef FIX15_UNPREMULTIPLY_TO_RGBA8_UNIT_ASSERT_SVH
`define FIX15_UNPREMULTIPLY_TO_RGBA8_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FX15UNP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fx15unp assertion failed");

// The consequent must hold after the antecedent, delayed by the dly argument.
`define FX15UNP_ASSERT_DLY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("fx15unp assertion failed");

`endif

// ===== hdl/fx15unp_pkg.sv =====
// Types, constants and arithmetic helpers for the unpremultiply unit.
package fx15unp_pkg;

  localparam int CHAN_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int NUM_W      = 24;
  localparam int NCOL       = 3;
  localparam int DEN_STAGES = 5;
  localparam int PIPE_DEPTH = 6;

  localparam logic [BYTE_W-1:0] BYTE_MAX   = 8'd255;
  localparam logic [NUM_W-1:0]  HALF_FIX15 = 24'd16384;
  localparam int                FIX15_SHIFT = 15;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
    logic [CHAN_W-1:0] alpha_in;
  } fx15unp_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red_out;
    logic [BYTE_W-1:0] green_out;
    logic [BYTE_W-1:0] blue_out;
    logic [BYTE_W-1:0] alpha_out;
  } fx15unp_out_t;

  // Multiplies by 255 as a shift and a subtract.
  function automatic logic [NUM_W-1:0] scale255(input logic [CHAN_W-1:0] v);
    return {v, 8'h00} - {8'h00, v};
  endfunction

  // One restoring division step: the top bit is the quotient bit, the rest
  // is the new remainder.
  function automatic logic [NUM_W:0] div_step(input logic [NUM_W-1:0] rem,
                                              input logic [CHAN_W-1:0] den,
                                              input int unsigned sh);
    logic [NUM_W-1:0] dsh;
    dsh = NUM_W'(den) << sh;
    if (rem >= dsh) begin
      return {1'b1, rem - dsh};
    end
    return {1'b0, rem};
  endfunction

endpackage

// ===== hdl/fx15unp_div_lane.sv =====
// Pipelined saturating 8-bit quotient divider for one color channel.
module fx15unp_div_lane
  import fx15unp_pkg::*;
(
  input  logic                                clk,
  input  logic [NUM_W-1:0]                    num_i,
  input  logic [DEN_STAGES-1:0][CHAN_W-1:0]   den_i,
  output logic [BYTE_W-1:0]                   q_o
);

  logic [3:0][NUM_W-1:0]  rem_r;
  logic [3:0][NUM_W-1:0]  rem_nxt;
  logic [3:0][BYTE_W-1:0] quo_r;
  logic [3:0][BYTE_W-1:0] quo_nxt;
  logic [3:0]             ovf_r;
  logic                   ovf_nxt;
  logic [BYTE_W-1:0]      q_r;
  logic [BYTE_W-1:0]      q_nxt;

  always_comb begin
    logic [NUM_W:0] s;
    logic [NUM_W:0] t;

    ovf_nxt    = num_i >= {den_i[0], 8'h00};
    s          = div_step(num_i, den_i[0], 7);
    rem_nxt[0] = s[NUM_W-1:0];
    quo_nxt[0] = {s[NUM_W], 7'b0};

    s          = div_step(rem_r[0], den_i[1], 6);
    t          = div_step(s[NUM_W-1:0], den_i[1], 5);
    rem_nxt[1] = t[NUM_W-1:0];
    quo_nxt[1] = quo_r[0] | {1'b0, s[NUM_W], t[NUM_W], 5'b0};

    s          = div_step(rem_r[1], den_i[2], 4);
    t          = div_step(s[NUM_W-1:0], den_i[2], 3);
    rem_nxt[2] = t[NUM_W-1:0];
    quo_nxt[2] = quo_r[1] | {3'b0, s[NUM_W], t[NUM_W], 3'b0};

    s          = div_step(rem_r[2], den_i[3], 2);
    t          = div_step(s[NUM_W-1:0], den_i[3], 1);
    rem_nxt[3] = t[NUM_W-1:0];
    quo_nxt[3] = quo_r[2] | {5'b0, s[NUM_W], t[NUM_W], 1'b0};

    s     = div_step(rem_r[3], den_i[4], 0);
    q_nxt = ovf_r[3] ? BYTE_MAX : (quo_r[3] | {7'b0, s[NUM_W]});
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    ovf_r <= {ovf_r[2:0], ovf_nxt};
    q_r   <= q_nxt;
  end

  assign q_o = q_r;

endmodule

// ===== hdl/fix15_unpremultiply_to_rgba8_unit.sv =====
// Top level of the premultiplied fix15 to straight RGBA8 converter.
//
//   channel  handshake         payload                  direction
//   input    start / busy      in_data  (fx15unp_in_t)  in
//   result   out_valid         out_data (fx15unp_out_t) out
//
// One pixel is accepted per cycle, and busy stays low after reset.
// Each result passes the input registers, then the pipelined divider that
// yields about two quotient bits per stage, then the output register.
// Reset clears only the valid bits; payload registers are not reset.
// The result strobe is never held off, so the pipeline never stalls.
`include "fix15_unpremultiply_to_rgba8_unit_assert.svh"

module fix15_unpremultiply_to_rgba8_unit
  import fx15unp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  fx15unp_in_t  in_data,
  output logic         out_valid,
  output fx15unp_out_t out_data
);

  logic                               accept;
  logic [NCOL-1:0][CHAN_W-1:0]        chan_in;
  logic [NCOL-1:0][NUM_W-1:0]         num_r;
  logic [NCOL-1:0][NUM_W-1:0]         num_nxt;
  logic [NCOL-1:0][BYTE_W-1:0]        q_lane;
  logic [DEN_STAGES-1:0][CHAN_W-1:0]  den_r;
  logic [PIPE_DEPTH-1:0]              vld_r;
  logic [PIPE_DEPTH-1:0]              zero_r;
  logic [PIPE_DEPTH-1:0][BYTE_W-1:0]  alpha_r;
  logic [NUM_W-1:0]                   alpha_sum;
  logic [BYTE_W-1:0]                  alpha_nxt;
  logic                               out_valid_r;
  fx15unp_out_t                       out_data_r;
  logic                               opaque_in;
  logic                               zero_out;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign chan_in[0] = in_data.red_in;
  assign chan_in[1] = in_data.green_in;
  assign chan_in[2] = in_data.blue_in;

  always_comb begin
    for (int i = 0; i < NCOL; i++) begin
      num_nxt[i] = scale255(chan_in[i]) + NUM_W'(in_data.alpha_in >> 1);
    end
    alpha_sum = scale255(in_data.alpha_in) + HALF_FIX15;
    if (alpha_sum[NUM_W-1:FIX15_SHIFT] > {1'b0, BYTE_MAX}) begin
      alpha_nxt = BYTE_MAX;
    end else begin
      alpha_nxt = alpha_sum[FIX15_SHIFT+BYTE_W-1:FIX15_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[PIPE_DEPTH-2:0], accept};
      out_valid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    num_r   <= num_nxt;
    den_r   <= {den_r[DEN_STAGES-2:0], in_data.alpha_in};
    zero_r  <= {zero_r[PIPE_DEPTH-2:0], in_data.alpha_in == '0};
    alpha_r <= {alpha_r[PIPE_DEPTH-2:0], alpha_nxt};
    if (zero_r[PIPE_DEPTH-1]) begin
      out_data_r <= '0;
    end else begin
      out_data_r.red_out   <= q_lane[0];
      out_data_r.green_out <= q_lane[1];
      out_data_r.blue_out  <= q_lane[2];
      out_data_r.alpha_out <= alpha_r[PIPE_DEPTH-1];
    end
  end

  for (genvar i = 0; i < NCOL; i++) begin : g_lane
    fx15unp_div_lane u_lane (
      .clk   (clk),
      .num_i (num_r[i]),
      .den_i (den_r),
      .q_o   (q_lane[i])
    );
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign opaque_in = accept && in_data.alpha_in == 16'h8000;
  assign zero_out  = vld_r[PIPE_DEPTH-1] && zero_r[PIPE_DEPTH-1];

  `FX15UNP_ASSERT_DLY(a_beat_leaves, start && !busy, 7, out_valid)
  `FX15UNP_ASSERT_DLY(a_opaque_alpha, opaque_in, 7, out_valid && out_data.alpha_out == 8'hFF)
  `FX15UNP_ASSERT_DLY(a_zero_alpha_clears, zero_out, 1, out_data == '0)

endmodule
